// ----- rtl/core/gtbd_pkg.sv -----
// Shared constants, result record and default parameters for the texture bind detector.
// Used by gtbd_back, the top level and the testbench; depends on nothing.
`default_nettype none

package gtbd_pkg;

    // Default sizes handed to the top level
    localparam int TABLE_DEPTH_DEF       = 256;
    localparam int RECT_SEARCH_WORDS_DEF = 10;
    localparam int UNIT_COUNT_DEF        = 16;

    // Command stream encoding
    localparam logic [16:0] OFFSET_METHOD = 17'h01a00;
    localparam logic [4:0]  RECT_LOW_BITS = 5'h18;
    localparam logic [4:0]  METHOD_SHIFT  = 5'd5;
    localparam logic [31:0] SPAN_RESET    = 32'h0f900000;

    // Format bases
    localparam logic [7:0] BASE_MASK   = 8'h9f;
    localparam logic [7:0] FMT_B8      = 8'h81;
    localparam logic [7:0] FMT_DXT1    = 8'h86;
    localparam logic [7:0] FMT_DXT23   = 8'h87;
    localparam logic [7:0] FMT_DXT45   = 8'h88;
    localparam logic [7:0] FMT_EXTRA_A = 8'had;
    localparam logic [7:0] FMT_EXTRA_B = 8'hae;

    // Table outcome codes
    localparam logic [1:0] ST_ADDED = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // One reported hit
    typedef struct packed {
        logic [31:0] offset;
        logic [7:0]  format;
        logic [12:0] width;
        logic [12:0] height;
        logic [3:0]  mips;
        logic        main_mem;
        logic [3:0]  unit;
        logic [26:0] bytes;
        logic [1:0]  status;
        logic        last;
    } res_t;

endpackage

`default_nettype wire

// ----- rtl/core/gtbd_jobq.sv -----
// Two-entry request queue between the front and back parts.
// Generic width; no package dependency.
`default_nettype none

module gtbd_jobq #(
    parameter int W = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [W-1:0] in_data,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [W-1:0]      out_data
);

    logic [W-1:0] slot_reg [2];
    logic         wp_reg;
    logic         rp_reg;
    logic [1:0]   cnt_reg;
    logic         push;
    logic         pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = slot_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wp_reg] <= in_data;
    end

endmodule

`default_nettype wire

// ----- rtl/core/gtbd_front.sv -----
// Front part: keeps the word window and issues a window snapshot request per trigger.
// Depends on no package items; paired with gtbd_back through gtbd_jobq.
`default_nettype none

module gtbd_front #(
    parameter int RSW = 10
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [31:0]   cmd_word,
    input  wire logic          run_end,
    input  wire logic          restart,
    output logic               job_valid,
    input  wire logic          job_ready,
    output logic [((RSW + 2 > 8) ? RSW + 2 : 8) * 32 +
                  $clog2(((RSW + 2 > 8) ? RSW + 2 : 8) + 1) + 2:0] job_data
);

    localparam int WIN = (RSW + 2 > 8) ? RSW + 2 : 8;
    localparam int NW  = $clog2(WIN + 1);

    logic [31:0]   win_reg [WIN];
    logic [NW-1:0] fill_reg;
    logic [31:0]   snap [WIN];
    logic [NW-1:0] base;
    logic [NW-1:0] n_new;
    logic          full;
    logic          accept;

    // append the word into a snapshot of the window
    always_comb
    begin
        base  = restart ? '0 : fill_reg;
        n_new = base + NW'(1);
        full  = (n_new == NW'(WIN));
        for (int i = 0; i < WIN; i++)
        begin
            snap[i] = (NW'(i) == base) ? cmd_word : win_reg[i];
            job_data[i*32 +: 32] = snap[i];
        end
        // layout above the window: n, flush, try, clear
        job_data[WIN*32 +: NW] = n_new;
        job_data[WIN*32 + NW]     = run_end;
        job_data[WIN*32 + NW + 1] = run_end || full;
        job_data[WIN*32 + NW + 2] = restart;
    end

    assign in_ready  = job_ready;
    assign accept    = in_valid && in_ready;
    assign job_valid = in_valid && (restart || run_end || full);

    // fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else if (accept)
        begin
            if (run_end)
                fill_reg <= '0;
            else if (full)
                fill_reg <= NW'(WIN - 1);
            else
                fill_reg <= n_new;
        end
    end

    // window words; slides by one once full
    always_ff @(posedge clk)
    begin
        if (accept && !run_end)
        begin
            for (int i = 0; i < WIN; i++)
            begin
                if (full && i < WIN - 1)
                    win_reg[i] <= snap[i + 1];
                else
                    win_reg[i] <= snap[i];
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/gtbd_back.sv -----
// Back part: tries window positions, sums the mip chain, searches the offset table.
// Depends on gtbd_pkg (res_t, encodings, status codes).
`default_nettype none

module gtbd_back #(
    parameter int TD  = 256,
    parameter int RSW = 10,
    parameter int UC  = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [31:0]   video_span,
    input  wire logic          job_valid,
    output logic               job_ready,
    input  wire logic [((RSW + 2 > 8) ? RSW + 2 : 8) * 32 +
                       $clog2(((RSW + 2 > 8) ? RSW + 2 : 8) + 1) + 2:0] job_data,
    output logic               res_valid,
    input  wire logic          res_ready,
    output gtbd_pkg::res_t     res
);

    localparam int WIN = (RSW + 2 > 8) ? RSW + 2 : 8;
    localparam int NW  = $clog2(WIN + 1);
    localparam int CW  = $clog2(TD + 1);
    localparam int AW  = (TD > 1) ? $clog2(TD) : 1;
    localparam logic [16:0] METH_END = 17'(32'h1a00 + UC * 32);

    typedef enum logic [2:0] {S_IDLE, S_EVAL, S_MIPS, S_TSRCH, S_EMIT, S_ADV, S_FINISH} state_t;

    state_t         state_reg;
    logic [31:0]    w_reg [WIN];
    logic [NW-1:0]  n_reg;
    logic           single_reg;

    logic [31:0]    off_c_reg;
    logic [7:0]     fmt_c_reg;
    logic [12:0]    wd_c_reg;
    logic [12:0]    ht_c_reg;
    logic [3:0]     mips_c_reg;
    logic           main_c_reg;
    logic [3:0]     unit_c_reg;
    logic [3:0]     lv_reg;
    logic [26:0]    acc_reg;
    logic [1:0]     status_reg;

    logic [31:0]    tab_mem [TD];
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  idx_reg;
    logic           cmp_vld_reg;
    logic [31:0]    rdata_reg;

    gtbd_pkg::res_t held_reg;
    logic           held_vld_reg;
    gtbd_pkg::res_t out_reg;
    logic           out_vld_reg;

    // position decode
    logic [31:0] hdr, off, fw, rect;
    logic [10:0] cnt;
    logic [16:0] meth, rm;
    logic [7:0]  fmt, base;
    logic [7:0]  mips;
    logic [1:0]  ctx;
    logic        hdr_ok, fmt_ok, span_ok, dim_ok, hit;
    logic [15:0] rw, rh;

    function automatic logic pow2_ok(input logic [15:0] v);
        pow2_ok = (v >= 16'd8) && (v <= 16'd4096) && ((v & (v - 16'd1)) == 16'd0);
    endfunction

    always_comb
    begin
        hdr  = w_reg[0];
        off  = w_reg[1];
        fw   = w_reg[2];
        cnt  = hdr[28:18];
        meth = {hdr[16:2], 2'b00};
        rm   = {meth[16:5], gtbd_pkg::RECT_LOW_BITS};
        ctx  = fw[1:0];
        fmt  = fw[15:8];
        mips = fw[23:16];
        base = fmt & gtbd_pkg::BASE_MASK;
        hdr_ok = (n_reg >= NW'(3)) && (cnt >= 11'd2) && (cnt <= 11'd64)
               && (meth >= gtbd_pkg::OFFSET_METHOD) && (meth < METH_END)
               && (meth[4:0] == 5'd0);
        fmt_ok = (base >= gtbd_pkg::FMT_B8) || (fmt == gtbd_pkg::FMT_EXTRA_A)
               || (fmt == gtbd_pkg::FMT_EXTRA_B);
        dim_ok = ((ctx == 2'd1) || (ctx == 2'd2)) && (fw[7:4] == 4'd2)
               && (mips != 8'd0) && (mips <= 8'd13);
        span_ok = !((ctx == 2'd1) && (off >= video_span));
        // batched rect at word +7, else first rect command in range
        rect = 32'd0;
        if ((cnt >= 11'd7) && (n_reg > NW'(7)))
            rect = w_reg[7];
        else
        begin
            for (int k = RSW; k >= 3; k--)
            begin
                if ((NW'(k + 1) < n_reg) && (w_reg[k][16:2] == rm[16:2])
                    && (w_reg[k][28:18] != 11'd0))
                    rect = w_reg[k + 1];
            end
        end
        rw  = rect[31:16];
        rh  = rect[15:0];
        hit = hdr_ok && fmt_ok && dim_ok && span_ok && pow2_ok(rw) && pow2_ok(rh);
    end

    // one mip level per cycle
    logic [12:0] la, lb, la1, lb1, bw, bh, opa, opb;
    logic [25:0] prod;
    logic [7:0]  cbase;
    logic        blk;
    logic [2:0]  sh;
    logic [26:0] lvl_bytes;

    always_comb
    begin
        la    = wd_c_reg >> lv_reg;
        lb    = ht_c_reg >> lv_reg;
        la1   = (la == 13'd0) ? 13'd1 : la;
        lb1   = (lb == 13'd0) ? 13'd1 : lb;
        bw    = (la1 + 13'd3) >> 2;
        bh    = (lb1 + 13'd3) >> 2;
        cbase = fmt_c_reg & gtbd_pkg::BASE_MASK;
        unique case (cbase)
            gtbd_pkg::FMT_DXT1:  begin blk = 1'b1; sh = 3'd3; end
            gtbd_pkg::FMT_DXT23,
            gtbd_pkg::FMT_DXT45: begin blk = 1'b1; sh = 3'd4; end
            gtbd_pkg::FMT_B8:    begin blk = 1'b0; sh = 3'd0; end
            8'h82, 8'h83, 8'h84, 8'h8b, 8'h8f, 8'h95, 8'h97, 8'h9d:
                                 begin blk = 1'b0; sh = 3'd1; end
            default:             begin blk = 1'b0; sh = 3'd2; end
        endcase
        opa       = blk ? bw : la1;
        opb       = blk ? bh : lb1;
        prod      = opa * opb;
        lvl_bytes = {1'b0, prod} << sh;
    end

    // table search step decode
    logic tab_full, tab_dup, tab_rd, tab_add;

    always_comb
    begin
        tab_full = 1'b0;
        tab_dup  = 1'b0;
        tab_rd   = 1'b0;
        tab_add  = 1'b0;
        if (state_reg == S_TSRCH)
        begin
            priority if (count_reg >= CW'(TD))
                tab_full = 1'b1;
            else if (cmp_vld_reg && (rdata_reg == off_c_reg))
                tab_dup = 1'b1;
            else if (idx_reg < count_reg)
                tab_rd = 1'b1;
            else if (!cmp_vld_reg)
                tab_add = 1'b1;
        end
    end

    // offset table storage
    always_ff @(posedge clk)
    begin
        if (tab_add)
            tab_mem[count_reg[AW-1:0]] <= off_c_reg;
        if (tab_rd)
            rdata_reg <= tab_mem[idx_reg[AW-1:0]];
    end

    logic out_free;
    logic out_load;
    gtbd_pkg::res_t new_res;
    gtbd_pkg::res_t held_last;

    assign out_free  = !out_vld_reg || res_ready;
    assign out_load  = held_vld_reg && out_free
                     && ((state_reg == S_EMIT) || (state_reg == S_FINISH));
    assign job_ready = (state_reg == S_IDLE);
    assign res_valid = out_vld_reg;
    assign res       = out_reg;

    always_comb
    begin
        new_res.offset   = off_c_reg;
        new_res.format   = fmt_c_reg;
        new_res.width    = wd_c_reg;
        new_res.height   = ht_c_reg;
        new_res.mips     = mips_c_reg;
        new_res.main_mem = main_c_reg;
        new_res.unit     = unit_c_reg;
        new_res.bytes    = acc_reg;
        new_res.status   = status_reg;
        new_res.last     = 1'b0;
    end

    // final hit of a request carries the last mark
    always_comb
    begin
        held_last      = held_reg;
        held_last.last = 1'b1;
    end

    // sequencer with registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            cmp_vld_reg  <= 1'b0;
            held_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (out_vld_reg && res_ready && !out_load)
                out_vld_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        for (int i = 0; i < WIN; i++)
                            w_reg[i] <= job_data[i*32 +: 32];
                        n_reg      <= job_data[WIN*32 +: NW];
                        single_reg <= !job_data[WIN*32 + NW];
                        if (job_data[WIN*32 + NW + 2])
                            count_reg <= '0;
                        if (job_data[WIN*32 + NW + 1])
                            state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    off_c_reg  <= off;
                    fmt_c_reg  <= fmt;
                    wd_c_reg   <= rw[12:0];
                    ht_c_reg   <= rh[12:0];
                    mips_c_reg <= mips[3:0];
                    main_c_reg <= (ctx == 2'd2);
                    unit_c_reg <= 4'(meth[16:5] - gtbd_pkg::OFFSET_METHOD[16:5]);
                    lv_reg     <= 4'd0;
                    acc_reg    <= '0;
                    state_reg  <= hit ? S_MIPS : S_ADV;
                end
                S_MIPS:
                begin
                    acc_reg <= acc_reg + lvl_bytes;
                    lv_reg  <= lv_reg + 4'd1;
                    if (lv_reg == mips_c_reg - 4'd1)
                    begin
                        idx_reg     <= '0;
                        cmp_vld_reg <= 1'b0;
                        state_reg   <= S_TSRCH;
                    end
                end
                S_TSRCH:
                begin
                    priority if (tab_full)
                    begin
                        status_reg <= gtbd_pkg::ST_FULL;
                        state_reg  <= S_EMIT;
                    end
                    else if (tab_dup)
                    begin
                        status_reg  <= gtbd_pkg::ST_DUP;
                        cmp_vld_reg <= 1'b0;
                        state_reg   <= S_EMIT;
                    end
                    else if (tab_rd)
                    begin
                        idx_reg     <= idx_reg + CW'(1);
                        cmp_vld_reg <= 1'b1;
                    end
                    else if (tab_add)
                    begin
                        count_reg  <= count_reg + CW'(1);
                        status_reg <= gtbd_pkg::ST_ADDED;
                        state_reg  <= S_EMIT;
                    end
                    else
                        cmp_vld_reg <= 1'b0;
                end
                S_EMIT:
                begin
                    // hold one hit back so the final one can be marked
                    if (!held_vld_reg)
                    begin
                        held_reg     <= new_res;
                        held_vld_reg <= 1'b1;
                        state_reg    <= S_ADV;
                    end
                    else if (out_free)
                    begin
                        out_reg     <= held_reg;
                        out_vld_reg <= 1'b1;
                        held_reg    <= new_res;
                        state_reg   <= S_ADV;
                    end
                end
                S_ADV:
                begin
                    if (single_reg || (n_reg <= NW'(1)))
                        state_reg <= S_FINISH;
                    else
                    begin
                        for (int i = 0; i < WIN - 1; i++)
                            w_reg[i] <= w_reg[i + 1];
                        n_reg     <= n_reg - NW'(1);
                        state_reg <= S_EVAL;
                    end
                end
                S_FINISH:
                begin
                    if (!held_vld_reg)
                        state_reg <= S_IDLE;
                    else if (out_free)
                    begin
                        out_reg      <= held_last;
                        out_vld_reg  <= 1'b1;
                        held_vld_reg <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/gpu_texture_bind_detector_core.sv -----
// Flow: a word that fills the window, ends a run or restarts issues a request to the queue;
// the back part takes it when idle. Each tried position steps S_EVAL and S_ADV; a hit also
// steps S_MIPS per mip level, S_TSRCH through the table and S_EMIT, which waits for room.
// Throughput: 1 word per cycle while the queue has room; the queue holds 2 requests.
// Reset clears the window fill and table count, sets video_span to 0x0F900000; no sweep.
// Top level; depends on gtbd_pkg, gtbd_front, gtbd_jobq, gtbd_back.
`default_nettype none

module gpu_texture_bind_detector_core #(
    parameter int TABLE_DEPTH       = gtbd_pkg::TABLE_DEPTH_DEF,
    parameter int RECT_SEARCH_WORDS = gtbd_pkg::RECT_SEARCH_WORDS_DEF,
    parameter int UNIT_COUNT        = gtbd_pkg::UNIT_COUNT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] cmd_word,
    input  wire logic        run_end,
    input  wire logic        restart,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      tex_offset,
    output logic [7:0]       tex_format,
    output logic [12:0]      tex_width,
    output logic [12:0]      tex_height,
    output logic [3:0]       mip_levels,
    output logic             in_main_memory,
    output logic [3:0]       texture_unit,
    output logic [26:0]      byte_size,
    output logic [1:0]       table_status,
    output logic             last_result
);

    localparam int WIN = (RECT_SEARCH_WORDS + 2 > 8) ? RECT_SEARCH_WORDS + 2 : 8;
    localparam int JW  = WIN * 32 + $clog2(WIN + 1) + 3;

    logic [31:0]    span_reg;
    logic           fq_valid, fq_ready, qb_valid, qb_ready;
    logic [JW-1:0]  fq_data, qb_data;
    gtbd_pkg::res_t res;

    // video span register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            span_reg <= gtbd_pkg::SPAN_RESET;
        else if (cfg_valid)
            span_reg <= cfg_data;
    end

    gtbd_front #(.RSW(RECT_SEARCH_WORDS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd_word  (cmd_word),
        .run_end   (run_end),
        .restart   (restart),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job_data  (fq_data)
    );

    gtbd_jobq #(.W(JW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    gtbd_back #(.TD(TABLE_DEPTH), .RSW(RECT_SEARCH_WORDS), .UC(UNIT_COUNT)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .video_span (span_reg),
        .job_valid  (qb_valid),
        .job_ready  (qb_ready),
        .job_data   (qb_data),
        .res_valid  (out_valid),
        .res_ready  (out_ready),
        .res        (res)
    );

    // result fields
    assign tex_offset     = res.offset;
    assign tex_format     = res.format;
    assign tex_width      = res.width;
    assign tex_height     = res.height;
    assign mip_levels     = res.mips;
    assign in_main_memory = res.main_mem;
    assign texture_unit   = res.unit;
    assign byte_size      = res.bytes;
    assign table_status   = res.status;
    assign last_result    = res.last;

endmodule

`default_nettype wire

// ----- rtl/core/gtbd_checker.sv -----
// Port-level checks for the texture bind detector, bound to the top level.
// Depends only on the top level's port names.
`default_nettype none

module gtbd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] tex_offset,
    input wire logic [12:0] tex_width,
    input wire logic [12:0] tex_height,
    input wire logic [3:0]  mip_levels,
    input wire logic [1:0]  table_status,
    input wire logic        last_result
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tex_offset) && $stable(last_result))
        else $error("result changed while stalled");

    // status code is one of the three outcomes
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> table_status != 2'd3)
        else $error("bad table status");

    // sides are powers of two of at least 8
    a_sides: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot(tex_width) && $onehot(tex_height)
                      && tex_width >= 13'd8 && tex_height >= 13'd8)
        else $error("bad texture side");

    // mip count in range
    a_mips: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> mip_levels != 4'd0 && mip_levels <= 4'd13)
        else $error("bad mip count");

endmodule

bind gpu_texture_bind_detector_core gtbd_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .tex_offset   (tex_offset),
    .tex_width    (tex_width),
    .tex_height   (tex_height),
    .mip_levels   (mip_levels),
    .table_status (table_status),
    .last_result  (last_result)
);

`default_nettype wire

// ----- verif/tb_gpu_texture_bind_detector_core.sv -----
// Testbench for gpu_texture_bind_detector_core: random and directed command streams,
// a built-in predictor of texture hits, and an in-order result scoreboard.
// Depends on gtbd_pkg and the core RTL.
`default_nettype none

module tb_gpu_texture_bind_detector_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TBL_DEPTH = 256;
    localparam int SEARCH_WORDS = 10;
    localparam int NUM_UNITS = 16;
    localparam int WIN = (SEARCH_WORDS + 2 > 8) ? SEARCH_WORDS + 2 : 8;
    localparam logic [16:0] RECT_METHOD = 17'h01a18;
    localparam logic [16:0] METHOD_STRIDE = 17'h20;
    localparam logic [31:0] METHOD_MASK = 32'h1fffc;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [31:0] word;
        logic        end_run;
        logic        clear;
    } cmd_req_t;

    logic clk, rst_n;
    logic cfg_valid, cfg_ready;
    logic [31:0] cfg_data;
    logic in_valid, in_ready;
    logic [31:0] cmd_word;
    logic run_end, restart;
    logic out_valid, out_ready;
    logic [31:0] tex_offset;
    logic [7:0] tex_format;
    logic [12:0] tex_width, tex_height;
    logic [3:0] mip_levels;
    logic in_main_memory;
    logic [3:0] texture_unit;
    logic [26:0] byte_size;
    logic [1:0] table_status;
    logic last_result;

    gpu_texture_bind_detector_core dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .cmd_word(cmd_word),
        .run_end(run_end), .restart(restart),
        .out_valid(out_valid), .out_ready(out_ready),
        .tex_offset(tex_offset), .tex_format(tex_format), .tex_width(tex_width),
        .tex_height(tex_height), .mip_levels(mip_levels),
        .in_main_memory(in_main_memory), .texture_unit(texture_unit),
        .byte_size(byte_size), .table_status(table_status), .last_result(last_result)
    );

    // Predictor state
    logic [31:0] span_reg;
    logic [31:0] win_words [WIN];
    int          win_fill;
    logic [31:0] offset_table [TBL_DEPTH];
    int          table_count;

    cmd_req_t           pending_cmds[$];
    gtbd_pkg::res_t     expected_hits[$];
    int                 mismatches;
    int                 stall_cycles;
    bit                 quiet_mode;
    int                 hold_req;
    int                 hold_done;
    int                 hold_left;
    logic               in_ready_seen;

    function automatic bit fmt_known(logic [7:0] f);
        logic [7:0] b;
        b = f & gtbd_pkg::BASE_MASK;
        return (b >= gtbd_pkg::FMT_B8 && b <= 8'h9f) || f == gtbd_pkg::FMT_EXTRA_A
            || f == gtbd_pkg::FMT_EXTRA_B;
    endfunction

    function automatic logic [31:0] level_bytes(logic [7:0] f, logic [31:0] w, logic [31:0] h);
        logic [31:0] bw, bh;
        bw = (w + 3) / 4;
        bh = (h + 3) / 4;
        case (f & gtbd_pkg::BASE_MASK)
            gtbd_pkg::FMT_DXT1: return bw * bh * 8;
            gtbd_pkg::FMT_DXT23, gtbd_pkg::FMT_DXT45: return bw * bh * 16;
            gtbd_pkg::FMT_B8: return w * h;
            8'h82, 8'h83, 8'h84, 8'h8b, 8'h8f, 8'h95, 8'h97, 8'h9d: return w * h * 2;
            default: return w * h * 4;
        endcase
    endfunction

    function automatic bit side_ok(logic [31:0] v);
        return v >= 8 && v <= 4096 && (v & (v - 1)) == 0;
    endfunction

    // Decode one window position as a texture-offset command
    function automatic void probe_position(int p, int n);
        logic [31:0] hdr, cnt, meth, unit, off, fw, ctx, rect, x, w, h, total, a, b, rm;
        logic [7:0] fmt;
        logic [31:0] mips;
        logic [1:0] st;
        gtbd_pkg::res_t r;
        if (p + 2 >= n) return;
        hdr = win_words[p];
        cnt = (hdr >> 18) & 32'h7ff;
        meth = hdr & METHOD_MASK;
        if (cnt < 2 || cnt > 64) return;
        if (meth < gtbd_pkg::OFFSET_METHOD
            || meth >= gtbd_pkg::OFFSET_METHOD + NUM_UNITS * METHOD_STRIDE) return;
        if ((meth - gtbd_pkg::OFFSET_METHOD) % METHOD_STRIDE != 0) return;
        unit = (meth - gtbd_pkg::OFFSET_METHOD) / METHOD_STRIDE;
        off = win_words[p + 1];
        fw = win_words[p + 2];
        ctx = fw & 3;
        if (ctx != 1 && ctx != 2) return;
        fmt = fw[15:8];
        mips = (fw >> 16) & 8'hff;
        if (fw[7:4] != 2 || !fmt_known(fmt) || mips == 0 || mips > 13) return;
        if (ctx == 1 && off >= span_reg) return;
        rm = RECT_METHOD + unit * METHOD_STRIDE;
        rect = 0;
        if (cnt >= 7 && p + 7 < n) rect = win_words[p + 7];
        else begin
            for (int k = p + 3; k <= p + SEARCH_WORDS && k + 1 < n; k++) begin
                x = win_words[k];
                if ((x & METHOD_MASK) == rm && ((x >> 18) & 32'h7ff) >= 1) begin
                    rect = win_words[k + 1];
                    break;
                end
            end
        end
        w = rect[31:16];
        h = rect[15:0];
        if (!side_ok(w) || !side_ok(h)) return;
        total = 0;
        for (int lv = 0; lv < mips; lv++) begin
            a = w >> lv;
            b = h >> lv;
            total += level_bytes(fmt, a ? a : 1, b ? b : 1);
        end
        st = gtbd_pkg::ST_ADDED;
        if (table_count >= TBL_DEPTH) st = gtbd_pkg::ST_FULL;
        else begin
            for (int i = 0; i < table_count; i++)
                if (offset_table[i] == off) begin
                    st = gtbd_pkg::ST_DUP;
                    break;
                end
            if (st == gtbd_pkg::ST_ADDED) begin
                offset_table[table_count] = off;
                table_count++;
            end
        end
        r.offset = off;
        r.format = fmt;
        r.width = w[12:0];
        r.height = h[12:0];
        r.mips = mips[3:0];
        r.main_mem = (ctx == 2);
        r.unit = unit[3:0];
        r.bytes = total[26:0];
        r.status = st;
        r.last = 1'b0;
        expected_hits.push_back(r);
    endfunction

    // Advance the predictor by one accepted word
    function automatic void predict_word(cmd_req_t c);
        int before_n;
        before_n = expected_hits.size();
        if (c.clear) begin
            win_fill = 0;
            table_count = 0;
        end
        if (win_fill >= WIN) win_fill = WIN - 1;
        win_words[win_fill] = c.word;
        win_fill++;
        if (c.end_run) begin
            for (int p = 0; p < win_fill; p++) probe_position(p, win_fill);
            win_fill = 0;
        end else if (win_fill == WIN) begin
            probe_position(0, WIN);
            for (int i = 0; i < WIN - 1; i++) win_words[i] = win_words[i + 1];
            win_fill = WIN - 1;
        end
        if (expected_hits.size() > before_n)
            expected_hits[expected_hits.size() - 1].last = 1'b1;
    endfunction

    // Stimulus builders
    function automatic void add_word(logic [31:0] w, bit e = 0, bit c = 0);
        cmd_req_t r;
        r.word = w;
        r.end_run = e;
        r.clear = c;
        pending_cmds.push_back(r);
    endfunction

    function automatic logic [31:0] pick_side();
        return 32'd8 << $urandom_range(0, 9);
    endfunction

    function automatic logic [7:0] pick_format();
        case ($urandom_range(0, 7))
            0: return gtbd_pkg::FMT_DXT1;
            1: return gtbd_pkg::FMT_DXT23;
            2: return gtbd_pkg::FMT_DXT45;
            3: return gtbd_pkg::FMT_B8;
            4: return gtbd_pkg::FMT_EXTRA_A;
            5: return 8'h82 | ($urandom_range(0, 1) << 5);
            default: return 8'h80 | $urandom_range(1, 31) | ($urandom_range(0, 3) << 5);
        endcase
    endfunction

    // One texture command: offset header, offset, format, filler and a rect
    function automatic void add_texture(logic [31:0] off, bit batched, int junk);
        logic [31:0] unit, cnt, fw, sides, ctx;
        unit = $urandom_range(0, NUM_UNITS - 1);
        cnt = batched ? $urandom_range(7, 64) : $urandom_range(2, 6);
        ctx = $urandom_range(1, 2);
        fw = ctx | (32'd2 << 4) | (32'(pick_format()) << 8)
            | (32'($urandom_range(1, 13)) << 16) | ($urandom_range(0, 255) << 24);
        if ($urandom_range(0, 9) == 0) fw = $urandom;
        sides = (pick_side() << 16) | pick_side();
        if ($urandom_range(0, 9) == 0) sides = $urandom;
        add_word((cnt << 18) | (gtbd_pkg::OFFSET_METHOD + unit * METHOD_STRIDE));
        add_word(off);
        add_word(fw);
        if (batched) begin
            for (int i = 0; i < 4; i++) add_word($urandom);
            add_word(sides);
        end else begin
            for (int i = 0; i < junk; i++) add_word($urandom & ~32'h7ff);
            add_word((32'($urandom_range(1, 2047)) << 18) | (RECT_METHOD + unit * METHOD_STRIDE)
                | ($urandom_range(0, 1) << 17));
            add_word(sides);
        end
    endfunction

    task automatic write_span(logic [31:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        span_reg = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_and_wait();
        while (pending_cmds.size() != 0 || in_valid || expected_hits.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // Clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Driver: offers queued words, idles in random bursts
    int src_gap;
    always @(negedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            cmd_word <= '0;
            run_end <= 1'b0;
            restart <= 1'b0;
            src_gap <= 0;
        end else if (!in_valid || in_ready_seen) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                in_valid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
                cmd_req_t c;
                c = pending_cmds.pop_front();
                in_valid <= 1'b1;
                cmd_word <= c.word;
                run_end <= c.end_run;
                restart <= c.clear;
                if (!quiet_mode && $urandom_range(0, 7) == 0) src_gap <= $urandom_range(1, 4);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Acceptance tracking at the rising edge
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) in_ready_seen <= 1'b0;
        else begin
            in_ready_seen <= in_valid && in_ready;
            if (in_valid && in_ready) predict_word('{cmd_word, run_end, restart});
        end
    end

    // Receiver backpressure; a requested long hold is counted here
    int sink_gap;
    always @(negedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            sink_gap <= 0;
            hold_left <= 0;
            hold_done <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (hold_done != hold_req) begin
            hold_done <= hold_done + 1;
            hold_left <= HOLD_CYCLES - 1;
            out_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            out_ready <= 1'b0;
        end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
            sink_gap <= $urandom_range(0, 3);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Monitor and scoreboard
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            gtbd_pkg::res_t got, exp_r;
            got = '{tex_offset, tex_format, tex_width, tex_height, mip_levels,
                    in_main_memory, texture_unit, byte_size, table_status, last_result};
            if (expected_hits.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected hit %p", got);
            end else begin
                exp_r = expected_hits.pop_front();
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10) $display("hit differs: exp %p got %p", exp_r, got);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted request
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready) || hold_left > 0)
            stall_cycles <= 0;
        else if (pending_cmds.size() != 0 || expected_hits.size() != 0 || in_valid) begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("gpu_texture_bind_detector_core: mismatch");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] offs [8];
        mismatches = 0;
        stall_cycles = 0;
        quiet_mode = 0;
        hold_req = 0;
        span_reg = gtbd_pkg::SPAN_RESET;
        win_fill = 0;
        table_count = 0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: batched and searched rects, extremes, run tails, duplicates
        add_word(32'((64 << 18) | gtbd_pkg::OFFSET_METHOD), 0, 1);
        add_word(32'h0000_1000);
        add_word(32'h0d00_8621);
        for (int i = 0; i < 4; i++) add_word(32'hffff_ffff);
        add_word(32'h1000_1000);
        add_word(32'((2 << 18) | (gtbd_pkg::OFFSET_METHOD + 15 * METHOD_STRIDE)));
        add_word(32'h0000_1000);
        add_word(32'h0101_ae22);
        add_word(32'((1 << 18) | (RECT_METHOD + 15 * METHOD_STRIDE)));
        add_word(32'h0008_0008);
        add_word(32'((7 << 18) | gtbd_pkg::OFFSET_METHOD));
        add_word(32'hffff_fff0);
        add_word(32'h0301_8122, 1);
        add_word(32'h0);
        add_word(32'hffff_ffff, 1);
        add_word(32'h0, 1);
        add_word(32'((65 << 18) | gtbd_pkg::OFFSET_METHOD));
        add_word(32'h0);
        add_word(32'h0, 1);
        drain_and_wait();
        write_span(32'h0);
        add_word(32'((3 << 18) | (gtbd_pkg::OFFSET_METHOD + 2 * METHOD_STRIDE)));
        add_word(32'h0000_0100);
        add_word(32'h0401_8721);
        add_word(32'((1 << 18) | (RECT_METHOD + 2 * METHOD_STRIDE)));
        add_word(32'h0200_0010, 1);
        drain_and_wait();
        write_span(32'hffff_ffff);

        // Random: well-formed textures with random content, noise, run ends, restarts
        for (int i = 0; i < 8; i++) offs[i] = $urandom & ($urandom_range(0, 1) ? 32'hff : '1);
        for (int n = 0; n < 48; n++) begin
            int kind;
            kind = $urandom_range(0, 9);
            if (n == 24) begin
                drain_and_wait();
                write_span($urandom_range(0, 1) ? $urandom : 32'h0010_0000);
                // Long receiver hold while the sender keeps offering words
                hold_req++;
                for (int t = 0; t < 6; t++) add_texture(offs[t], 1, 0);
            end
            if (kind < 6)
                add_texture($urandom_range(0, 2) ? offs[$urandom_range(0, 7)] : $urandom,
                            $urandom_range(0, 1), $urandom_range(0, 5));
            else if (kind < 8)
                for (int j = $urandom_range(1, 4); j > 0; j--) add_word($urandom);
            else
                add_word($urandom, 1, $urandom_range(0, 3) == 0);
        end
        add_word($urandom, 1);
        drain_and_wait();

        // Reuse a few offsets after a restart so the table reports duplicates
        add_word(32'h0, 0, 1);
        for (int n = 0; n < 12; n++) begin
            add_word(32'((2 << 18) | gtbd_pkg::OFFSET_METHOD));
            add_word(32'(n % 6) << 4);
            add_word(32'h0101_8522);
            add_word(32'((1 << 18) | RECT_METHOD));
            add_word(32'h0008_0008);
            if (n % 4 == 3) add_word($urandom, 1);
        end
        add_word(32'h0, 1);
        drain_and_wait();

        // Final stretch without idling
        quiet_mode = 1;
        for (int n = 0; n < 12; n++) add_texture(offs[n % 8], n % 2, n % 4);
        add_word(32'h0, 1);
        drain_and_wait();

        if (mismatches == 0)
            $display("gpu_texture_bind_detector_core: match");
        else
            $display("gpu_texture_bind_detector_core: mismatch");
        $finish;
    end
endmodule

`default_nettype wire

// ----- gpu_texture_bind_detector_core.f -----
rtl/core/gtbd_pkg.sv
rtl/core/gtbd_jobq.sv
rtl/core/gtbd_front.sv
rtl/core/gtbd_back.sv
rtl/core/gpu_texture_bind_detector_core.sv
rtl/core/gtbd_checker.sv
verif/tb_gpu_texture_bind_detector_core.sv
